FILE: rtl/dsm_pkg.sv
// Shared types and constants of the datagram sequence monitor.
`default_nettype none

package dsm_pkg;

  // Opcodes of an input beat.
  localparam logic [1:0] OP_DATAGRAM = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  // Message types carried in the first payload word.
  localparam logic [31:0] TYPE_WARMUP = 32'd0;
  localparam logic [31:0] TYPE_DATA   = 32'd1;
  localparam logic [31:0] TYPE_QUIT   = 32'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LINGER   = 2'd0;
  localparam logic [1:0] CFG_HIST_EN  = 2'd1;
  localparam logic [1:0] CFG_EXPECTED = 2'd2;

  localparam logic [39:0] LINGER_RESET = 40'd100000000;
  localparam logic [31:0] PREV_SEQ_RESET = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    PH_INIT = 2'd0,
    PH_MEAS = 2'd1,
    PH_QUIT = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_LEN_MISMATCH = 3'd1,
    ST_BAD_TYPE     = 3'd2,
    ST_LINGER       = 3'd3,
    ST_IGNORED      = 3'd4
  } status_t;

  // Work kinds decided by the front end.
  typedef enum logic [2:0] {
    KIND_WARMUP   = 3'd0,
    KIND_DATA     = 3'd1,
    KIND_QUIT     = 3'd2,
    KIND_BAD_TYPE = 3'd3,
    KIND_TICK     = 3'd4,
    KIND_READ     = 3'd5,
    KIND_NOP      = 3'd6
  } kind_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] msg_type;
    logic [31:0] seq_number;
    logic [10:0] datagram_length;
    logic [63:0] timestamp_ns;
    logic [15:0] hist_index;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        halted;
    logic [1:0]  phase;
    logic [31:0] msg_count;
    logic [31:0] ooo_count;
    logic [31:0] warmup_count;
    logic [31:0] quit_count;
    logic [63:0] measured_ns;
    logic [7:0]  hist_value;
  } out_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] word;     // sequence number, or histogram read index
    logic [10:0] len;      // saturated length
    logic [63:0] ts;
    logic        hist_hit; // data beat that bumps its histogram entry
    logic        rd_ok;    // read index lies inside the histogram
  } cmd_t;

  // Result before the final time subtraction.
  typedef struct packed {
    status_t     status;
    logic        halted;
    phase_t      phase;
    logic [31:0] msg_count;
    logic [31:0] ooo_count;
    logic [31:0] warmup_count;
    logic [31:0] quit_count;
    logic [63:0] end_ns;
    logic [63:0] start_ns;
    logic [7:0]  hist_value;
  } pre_t;

endpackage

`default_nettype wire

FILE: rtl/dsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dsm_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/dsm_queue.sv
// Small register FIFO used between the monitor's pipeline parts.
`default_nettype none

module dsm_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          pop,
  output logic      [W-1:0]  rdata,
  output logic      [CW-1:0] count,
  output logic               full,
  output logic               empty
);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign rdata = slot_r[rd_ptr_r];
  assign count = count_r;
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dsm_front.sv
// Front end: configuration registers and classification of input beats.
`default_nettype none

module dsm_front import dsm_pkg::*; #(
  parameter int HIST_DEPTH  = 65536,
  parameter int MAX_PAYLOAD = 1472
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [39:0] cfg_data,
  input  wire logic        q_full,
  input  wire logic        clr_busy,
  output logic             push,
  output cmd_t             cmd,
  output logic [39:0]      linger
);

  logic [39:0] linger_r;
  logic        hist_en_r;
  logic [16:0] expected_r;
  logic [10:0] len_sat;

  assign cfg_ready = 1'b1;
  assign linger    = linger_r;

  // Configuration writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      linger_r   <= LINGER_RESET;
      hist_en_r  <= 1'b0;
      expected_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LINGER:   linger_r   <= cfg_data;
        CFG_HIST_EN:  hist_en_r  <= cfg_data[0];
        CFG_EXPECTED: expected_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Beats are taken while the queue has room and the histogram is cleared.
  assign in_ready = !q_full && !clr_busy;
  assign push     = in_valid && in_ready;

  // An overlong length saturates as a truncating receive would.
  assign len_sat = (32'(in_data.datagram_length) > 32'(MAX_PAYLOAD)) ?
                   11'(MAX_PAYLOAD) : in_data.datagram_length;

  // Classification of the beat.
  always_comb begin
    cmd.word     = in_data.seq_number;
    cmd.len      = len_sat;
    cmd.ts       = in_data.timestamp_ns;
    cmd.hist_hit = hist_en_r &&
                   (in_data.seq_number < 32'(expected_r)) &&
                   (in_data.seq_number < 32'(HIST_DEPTH));
    cmd.rd_ok    = (32'(in_data.hist_index) < 32'(HIST_DEPTH));
    cmd.kind     = KIND_NOP;
    unique case (in_data.opcode)
      OP_DATAGRAM: begin
        unique case (in_data.msg_type)
          TYPE_WARMUP: cmd.kind = KIND_WARMUP;
          TYPE_DATA:   cmd.kind = KIND_DATA;
          TYPE_QUIT:   cmd.kind = KIND_QUIT;
          default:     cmd.kind = KIND_BAD_TYPE;
        endcase
      end
      OP_TICK: cmd.kind = KIND_TICK;
      OP_READ: begin
        cmd.kind = KIND_READ;
        cmd.word = 32'(in_data.hist_index);
      end
      default: cmd.kind = KIND_NOP;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/dsm_back.sv
// Back end: monitor state, histogram read-modify-write and result build.
`default_nettype none

module dsm_back import dsm_pkg::*; #(
  parameter int HIST_DEPTH = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cmd_valid,
  input  wire cmd_t        cmd,
  output logic             cmd_pop,
  input  wire logic        pop_ok,
  input  wire logic [39:0] linger,
  output logic             res_push,
  output pre_t             res,
  output logic             clr_busy
);

  localparam int AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  // Clearing pass.
  logic          clr_busy_r, clr_busy_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // Execute stage.
  logic          y_valid_r;
  cmd_t          y_cmd_r;
  logic [AW-1:0] y_addr;

  // Histogram port and write forwarding.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  logic          lw_en_r;
  logic [AW-1:0] lw_addr_r;
  logic [7:0]    lw_data_r;
  logic [7:0]    hist_cur;
  logic          hist_we;

  // Monitor state.
  phase_t        phase_r, phase_nxt;
  logic [31:0]   prev_seq_r, prev_seq_nxt;
  logic [31:0]   msg_r, msg_nxt;
  logic [31:0]   ooo_r, ooo_nxt;
  logic [31:0]   warm_r, warm_nxt;
  logic [31:0]   quit_r, quit_nxt;
  logic [63:0]   start_r, start_nxt;
  logic [63:0]   stop_r, stop_nxt;
  logic [63:0]   last_r, last_nxt;
  logic [10:0]   latched_r, latched_nxt;
  logic          halt_r, halt_nxt;
  status_t       status;
  logic [7:0]    hval;
  logic [63:0]   idle_ns;

  assign clr_busy = clr_busy_r;

  // The histogram is swept to zero after reset, one entry a cycle.
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      if (clr_addr_r == AW'(HIST_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Issue stage: a command leaves the queue only when its result has room.
  assign cmd_pop = cmd_valid && pop_ok && !clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_valid_r <= 1'b0;
    end else begin
      y_valid_r <= cmd_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      y_cmd_r <= cmd;
    end
  end

  assign y_addr = y_cmd_r.word[AW-1:0];

  dsm_ram #(
    .W     (8),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cmd.word[AW-1:0]),
    .rdata (ram_rdata)
  );

  // The write of the previous cycle is not yet visible in the read data.
  assign hist_cur = (lw_en_r && (lw_addr_r == y_addr)) ? lw_data_r : ram_rdata;

  assign ram_we    = clr_busy_r || hist_we;
  assign ram_waddr = clr_busy_r ? clr_addr_r : y_addr;
  assign ram_wdata = clr_busy_r ? 8'd0 : hist_cur + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_en_r <= 1'b0;
    end else begin
      lw_en_r <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    lw_addr_r <= ram_waddr;
    lw_data_r <= ram_wdata;
  end

  assign idle_ns = y_cmd_r.ts - last_r;

  // Execute stage: state update of one command.
  always_comb begin
    phase_nxt    = phase_r;
    prev_seq_nxt = prev_seq_r;
    msg_nxt      = msg_r;
    ooo_nxt      = ooo_r;
    warm_nxt     = warm_r;
    quit_nxt     = quit_r;
    start_nxt    = start_r;
    stop_nxt     = stop_r;
    last_nxt     = last_r;
    latched_nxt  = latched_r;
    halt_nxt     = halt_r;
    status       = ST_OK;
    hval         = 8'd0;
    hist_we      = 1'b0;
    if (y_cmd_r.kind == KIND_READ) begin
      hval = y_cmd_r.rd_ok ? hist_cur : 8'd0;
    end else if (halt_r) begin
      status = ST_IGNORED;
    end else begin
      unique case (y_cmd_r.kind) inside
        KIND_TICK: begin
          if ((phase_r != PH_INIT) && (idle_ns > 64'(linger))) begin
            halt_nxt = 1'b1;
            status   = ST_LINGER;
          end
        end
        KIND_WARMUP, KIND_DATA, KIND_QUIT, KIND_BAD_TYPE: begin
          last_nxt = y_cmd_r.ts;
          if (latched_r == '0) begin
            latched_nxt = y_cmd_r.len;
          end
          if ((latched_r != '0) && (y_cmd_r.len != latched_r)) begin
            halt_nxt = 1'b1;
            status   = ST_LEN_MISMATCH;
          end else begin
            case (y_cmd_r.kind)
              KIND_WARMUP: begin
                msg_nxt  = '0;
                warm_nxt = warm_r + 1'b1;
                if (phase_r == PH_INIT) begin
                  start_nxt = y_cmd_r.ts;
                end
              end
              KIND_DATA: begin
                hist_we = y_cmd_r.hist_hit;
                if (y_cmd_r.word != prev_seq_r + 32'd1) begin
                  ooo_nxt = ooo_r + 1'b1;
                end
                prev_seq_nxt = y_cmd_r.word;
                msg_nxt      = msg_r + 1'b1;
                phase_nxt    = PH_MEAS;
              end
              KIND_QUIT: begin
                if (phase_r == PH_MEAS) begin
                  stop_nxt  = y_cmd_r.ts;
                  phase_nxt = PH_QUIT;
                end
                quit_nxt = quit_r + 1'b1;
              end
              default: begin
                halt_nxt = 1'b1;
                status   = ST_BAD_TYPE;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
    hist_we = hist_we && y_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_INIT;
      prev_seq_r <= PREV_SEQ_RESET;
      msg_r      <= '0;
      ooo_r      <= '0;
      warm_r     <= '0;
      quit_r     <= '0;
      start_r    <= '0;
      stop_r     <= '0;
      last_r     <= '0;
      latched_r  <= '0;
      halt_r     <= 1'b0;
    end else if (y_valid_r) begin
      phase_r    <= phase_nxt;
      prev_seq_r <= prev_seq_nxt;
      msg_r      <= msg_nxt;
      ooo_r      <= ooo_nxt;
      warm_r     <= warm_nxt;
      quit_r     <= quit_nxt;
      start_r    <= start_nxt;
      stop_r     <= stop_nxt;
      last_r     <= last_nxt;
      latched_r  <= latched_nxt;
      halt_r     <= halt_nxt;
    end
  end

  // Result from the updated state.
  assign res_push = y_valid_r;

  always_comb begin
    res.status       = status;
    res.halted       = halt_nxt;
    res.phase        = phase_nxt;
    res.msg_count    = msg_nxt;
    res.ooo_count    = ooo_nxt;
    res.warmup_count = warm_nxt;
    res.quit_count   = quit_nxt;
    res.end_ns       = (phase_nxt == PH_MEAS) ? last_nxt : stop_nxt;
    res.start_ns     = start_nxt;
    res.hist_value   = hval;
  end

endmodule

`default_nettype wire

FILE: rtl/datagram_sequence_monitor_core.sv
// Top level of the datagram sequence monitor.
//
// Input beats (in_valid/in_ready, in_data) carry a datagram descriptor, an
// idle tick or a histogram read; each beat gives exactly one result beat on
// out_valid/out_ready, out_data, in the order taken. Registers are written
// on the cfg_ channel, which is always ready, by the user only while the
// block is idle, which the block leaves unenforced. One beat a cycle is
// sustained while out_ready is high; the histogram read-modify-write in
// the back end is pipelined over the RAM's registered read with write
// forwarding. A classified-command queue of two entries parts the front
// end from the back end, and a result queue of two entries parts the back
// end from the receiver, so a stalled receiver fills the queues before
// in_ready drops. After reset a clearing pass writes every histogram entry
// to zero, one a cycle; in_ready stays low until it ends, while
// configuration writes are taken as usual.
`default_nettype none

module datagram_sequence_monitor_core import dsm_pkg::*; #(
  parameter int HIST_DEPTH  = 65536,
  parameter int MAX_PAYLOAD = 1472
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [39:0] cfg_data
);

  localparam int QDEPTH = 2;
  localparam int QCW    = $clog2(QDEPTH + 1);

  logic             q_push;
  cmd_t             q_wcmd;
  cmd_t             q_rcmd;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [QCW-1:0]   q_count;
  logic [39:0]      linger;
  logic             clr_busy;
  logic             res_push;
  pre_t             res;
  pre_t             res_head;
  logic             o_pop;
  logic             o_full;
  logic             o_empty;
  logic [QCW-1:0]   o_count;
  logic [QCW:0]     o_occ;
  logic             pop_ok;

  dsm_front #(
    .HIST_DEPTH  (HIST_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .clr_busy  (clr_busy),
    .push      (q_push),
    .cmd       (q_wcmd),
    .linger    (linger)
  );

  dsm_queue #(
    .W     ($bits(cmd_t)),
    .DEPTH (QDEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wcmd),
    .pop   (q_pop),
    .rdata (q_rcmd),
    .count (q_count),
    .full  (q_full),
    .empty (q_empty)
  );

  // A command may issue when the result queue still has a free slot once
  // the command in the execute stage has landed.
  assign o_pop  = out_valid && out_ready;
  assign o_occ  = (QCW + 1)'(o_count) + (QCW + 1)'(res_push) - (QCW + 1)'(o_pop);
  assign pop_ok = (o_occ <= (QCW + 1)'(QDEPTH - 1)) && (q_count != '0);

  dsm_back #(
    .HIST_DEPTH (HIST_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd       (q_rcmd),
    .cmd_pop   (q_pop),
    .pop_ok    (pop_ok),
    .linger    (linger),
    .res_push  (res_push),
    .res       (res),
    .clr_busy  (clr_busy)
  );

  dsm_queue #(
    .W     ($bits(pre_t)),
    .DEPTH (QDEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .pop   (o_pop),
    .rdata (res_head),
    .count (o_count),
    .full  (o_full),
    .empty (o_empty)
  );

  assign out_valid = !o_empty && !(o_full && 1'b0);

  // Output beat; the measured time is taken from the queued end and start.
  always_comb begin
    out_data.status       = res_head.status;
    out_data.halted       = res_head.halted;
    out_data.phase        = res_head.phase;
    out_data.msg_count    = res_head.msg_count;
    out_data.ooo_count    = res_head.ooo_count;
    out_data.warmup_count = res_head.warmup_count;
    out_data.quit_count   = res_head.quit_count;
    out_data.measured_ns  = res_head.end_ns - res_head.start_ns;
    out_data.hist_value   = res_head.hist_value;
  end

endmodule

`default_nettype wire
